// ----- design/srctl_pkg.sv -----
`timescale 1ns / 1ps

package srctl_pkg;

	localparam int unsigned DEBOUNCE_TICKS = 50;
	localparam int unsigned CHG_W          = $clog2(DEBOUNCE_TICKS + 1);
	localparam int unsigned DUR_W          = 32;
	localparam int unsigned CFG_IDX_W      = 1;
	localparam int unsigned IN_DATA_W      = 8;
	localparam int unsigned OUT_DATA_W     = 16;

	localparam logic [CHG_W-1:0] DEBOUNCE_LIMIT = CHG_W'(DEBOUNCE_TICKS);
	localparam logic [DUR_W-1:0] RUN_DURATION_RESET = DUR_W'(5000);

	localparam logic [CFG_IDX_W-1:0] REG_RUN_DURATION   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BARRIER_ENABLE = 1'd1;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_OPEN  = 2'd1,
		ACT_CLOSE = 2'd2,
		ACT_STOP  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		START_NONE         = 3'd0,
		START_TIMED_OPEN   = 3'd1,
		START_TIMED_CLOSE  = 3'd2,
		START_MANUAL_OPEN  = 3'd3,
		START_MANUAL_CLOSE = 3'd4
	} start_t;

	typedef struct packed {
		action_t action;
		logic    up_pressed;
		logic    down_pressed;
		logic    barrier_blocked;
	} tick_t;

	typedef struct packed {
		logic             open_level;
		logic             close_level;
		logic             run_active;
		logic             manual_active;
		logic [DUR_W-1:0] run_elapsed;
		logic [CHG_W-1:0] since_change;
		logic             last_up;
		logic             last_down;
	} ctl_state_t;

	typedef struct packed {
		logic   open_drive;
		logic   close_drive;
		logic   running;
		logic   manual_mode;
		start_t start_event;
		logic   stop_event;
		logic   barrier_event;
	} result_t;

	typedef struct packed {
		logic [DUR_W-1:0] run_duration;
		logic             barrier_enable;
	} cfg_t;

endpackage

// ----- design/srctl_step.sv -----
`timescale 1ns / 1ps

module srctl_step (
	input  srctl_pkg::cfg_t       cfg,
	input  srctl_pkg::ctl_state_t cur,
	input  srctl_pkg::tick_t      tick,
	output srctl_pkg::ctl_state_t nxt,
	output srctl_pkg::result_t    res
);
	import srctl_pkg::*;

	logic   ev_stop;
	logic   ev_barrier;
	start_t ev_start;
	logic   up_chg;
	logic   down_chg;

	always_comb begin
		nxt        = cur;
		ev_stop    = 1'b0;
		ev_barrier = 1'b0;
		ev_start   = START_NONE;
		up_chg     = tick.up_pressed != cur.last_up;
		down_chg   = tick.down_pressed != cur.last_down;

		if (cur.run_active && (cur.run_elapsed != {DUR_W{1'b1}})) begin
			nxt.run_elapsed = cur.run_elapsed + DUR_W'(1);
		end
		if (cur.since_change < DEBOUNCE_LIMIT) begin
			nxt.since_change = cur.since_change + CHG_W'(1);
		end

		case (tick.action) inside
			ACT_OPEN, ACT_CLOSE: begin
				if (nxt.run_active) begin
					ev_stop = 1'b1;
				end
				nxt.manual_active = 1'b0;
				nxt.open_level    = (tick.action == ACT_OPEN);
				nxt.close_level   = (tick.action == ACT_CLOSE);
				nxt.run_elapsed   = '0;
				nxt.run_active    = 1'b1;
				ev_start = (tick.action == ACT_OPEN) ? START_TIMED_OPEN : START_TIMED_CLOSE;
			end
			ACT_STOP: begin
				if (nxt.run_active) begin
					ev_stop = 1'b1;
				end
				nxt.open_level    = 1'b0;
				nxt.close_level   = 1'b0;
				nxt.run_active    = 1'b0;
				nxt.manual_active = 1'b0;
			end
			default: begin
			end
		endcase

		if (!nxt.manual_active && nxt.run_active
				&& (nxt.run_elapsed >= cfg.run_duration)) begin
			ev_stop           = 1'b1;
			nxt.open_level    = 1'b0;
			nxt.close_level   = 1'b0;
			nxt.run_active    = 1'b0;
			nxt.manual_active = 1'b0;
		end

		if (cfg.barrier_enable && nxt.run_active && tick.barrier_blocked) begin
			ev_stop           = 1'b1;
			ev_barrier        = 1'b1;
			nxt.open_level    = 1'b0;
			nxt.close_level   = 1'b0;
			nxt.run_active    = 1'b0;
			nxt.manual_active = 1'b0;
		end

		if ((nxt.since_change >= DEBOUNCE_LIMIT) && (up_chg || down_chg)) begin
			nxt.since_change = '0;
			if (tick.up_pressed && tick.down_pressed) begin
				nxt.open_level  = 1'b0;
				nxt.close_level = 1'b0;
				if (nxt.manual_active) begin
					nxt.manual_active = 1'b0;
					nxt.run_active    = 1'b0;
					ev_stop           = 1'b1;
				end
				nxt.last_up   = 1'b1;
				nxt.last_down = 1'b1;
			end else begin
				if (up_chg) begin
					if (tick.up_pressed) begin
						nxt.close_level   = 1'b0;
						nxt.open_level    = 1'b1;
						nxt.manual_active = 1'b1;
						nxt.run_active    = 1'b1;
						ev_start          = START_MANUAL_OPEN;
					end else begin
						nxt.open_level = 1'b0;
						if (nxt.run_active) begin
							ev_stop = 1'b1;
						end
						nxt.manual_active = 1'b0;
						nxt.run_active    = 1'b0;
					end
					nxt.last_up = tick.up_pressed;
				end
				if (down_chg) begin
					if (tick.down_pressed) begin
						nxt.open_level    = 1'b0;
						nxt.close_level   = 1'b1;
						nxt.manual_active = 1'b1;
						nxt.run_active    = 1'b1;
						ev_start          = START_MANUAL_CLOSE;
					end else begin
						nxt.close_level = 1'b0;
						if (nxt.run_active) begin
							ev_stop = 1'b1;
						end
						nxt.manual_active = 1'b0;
						nxt.run_active    = 1'b0;
					end
					nxt.last_down = tick.down_pressed;
				end
			end
		end

		res.open_drive    = nxt.open_level;
		res.close_drive   = nxt.close_level;
		res.running       = nxt.run_active;
		res.manual_mode   = nxt.manual_active;
		res.start_event   = ev_start;
		res.stop_event    = ev_stop;
		res.barrier_event = ev_barrier;
	end

endmodule

// ----- design/shutter_relay_controller_unit.sv -----
`timescale 1ns / 1ps

// channel   direction  width  fields
// s_axis    in         8      action[1:0], up_pressed, down_pressed, barrier_blocked
// m_axis    out        16     open_drive, close_drive, running, manual_mode,
//                             start_event[2:0], stop_event, barrier_event
// cfg       in         32     run_duration (index 0), barrier_enable (index 1)
//
// One item per cycle while the output is not stalled; an accepted item is held in the
// input register, then passes through the tick logic into the result register.
// arst_n clears all control state, run_duration to 5000 and barrier_enable to 1.
// A stalled result holds in the output register; input is still taken while the
// output register empties in the same cycle.

module shutter_relay_controller_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// action[1:0], up_pressed[2], down_pressed[3], barrier_blocked[4], zero fill
	input  logic [srctl_pkg::IN_DATA_W-1:0]        s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// open_drive[0], close_drive[1], running[2], manual_mode[3], start_event[6:4],
	// stop_event[7], barrier_event[8], zero fill
	output logic [srctl_pkg::OUT_DATA_W-1:0]       m_tdata,
	input  logic                                   cfg_we,
	input  logic [srctl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [srctl_pkg::DUR_W-1:0]            cfg_data
);
	import srctl_pkg::*;

	logic       valid_s1;
	tick_t      tick_s1;
	cfg_t       cfg_q;
	ctl_state_t state_q;
	ctl_state_t state_nxt;
	result_t    res_nxt;
	result_t    res_q;
	logic       advance;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	srctl_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.tick (tick_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_duration   <= RUN_DURATION_RESET;
			cfg_q.barrier_enable <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RUN_DURATION:   cfg_q.run_duration   <= cfg_data;
				REG_BARRIER_ENABLE: cfg_q.barrier_enable <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			tick_s1.action          <= action_t'(s_tdata[1:0]);
			tick_s1.up_pressed      <= s_tdata[2];
			tick_s1.down_pressed    <= s_tdata[3];
			tick_s1.barrier_blocked <= s_tdata[4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (advance) begin
				state_q  <= state_nxt;
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign m_tdata = {7'b0, res_q.barrier_event, res_q.stop_event, res_q.start_event,
		res_q.manual_mode, res_q.running, res_q.close_drive, res_q.open_drive};

endmodule

// ----- test/shutter_relay_controller_unit_test.sv -----
`timescale 1ns / 1ps

module shutter_relay_controller_unit_test;
	import srctl_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_TICKS = 70;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [DUR_W-1:0]      cfg_data  = '0;

	shutter_relay_controller_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	typedef struct packed {
		action_t  act;
		logic     up;
		logic     dn;
		logic     blk;
		int       reps;
		logic     typed;
		result_t  want;
	} step_t;

	// relay controller shadow
	logic [DUR_W-1:0] duration_set = RUN_DURATION_RESET;
	logic             barrier_set  = 1'b1;
	logic             drv_open     = 1'b0;
	logic             drv_close    = 1'b0;
	logic             run_on       = 1'b0;
	logic             manual_on    = 1'b0;
	logic             stopped_now  = 1'b0;
	logic [DUR_W-1:0] elapsed      = '0;
	logic [CHG_W-1:0] since_chg    = '0;
	logic             held_up      = 1'b0;
	logic             held_down    = 1'b0;

	result_t pending_drives[$];
	step_t   steps[$];
	int      fail_count    = 0;
	int      results_seen  = 0;
	int      ticks_sent    = 0;
	int      cycle_count   = 0;
	int      stall_left    = 0;
	bit      calm          = 1'b0;
	logic    sw_up         = 1'b0;
	logic    sw_down       = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void halt_run();
		if (run_on)
			stopped_now = 1'b1;
		drv_open  = 1'b0;
		drv_close = 1'b0;
		run_on    = 1'b0;
		manual_on = 1'b0;
	endfunction

	function automatic result_t shutter_tick(tick_t t);
		result_t r;
		start_t  started;
		logic    chg_up;
		logic    chg_down;
		r           = '0;
		started     = START_NONE;
		stopped_now = 1'b0;
		if (run_on && elapsed != '1)
			elapsed++;
		if (since_chg < DEBOUNCE_LIMIT)
			since_chg++;
		if (t.action == ACT_OPEN || t.action == ACT_CLOSE) begin
			halt_run();
			drv_open  = (t.action == ACT_OPEN);
			drv_close = (t.action == ACT_CLOSE);
			elapsed   = '0;
			run_on    = 1'b1;
			started   = (t.action == ACT_OPEN) ? START_TIMED_OPEN : START_TIMED_CLOSE;
		end else if (t.action == ACT_STOP) begin
			halt_run();
		end
		if (!manual_on && run_on && elapsed >= duration_set)
			halt_run();
		if (barrier_set && run_on && t.barrier_blocked) begin
			halt_run();
			r.barrier_event = 1'b1;
		end
		if (since_chg >= DEBOUNCE_LIMIT) begin
			chg_up   = (t.up_pressed != held_up);
			chg_down = (t.down_pressed != held_down);
			if (chg_up || chg_down) begin
				since_chg = '0;
				if (t.up_pressed && t.down_pressed) begin
					drv_open  = 1'b0;
					drv_close = 1'b0;
					if (manual_on) begin
						manual_on   = 1'b0;
						run_on      = 1'b0;
						stopped_now = 1'b1;
					end
					held_up   = 1'b1;
					held_down = 1'b1;
				end else begin
					if (chg_up) begin
						if (t.up_pressed) begin
							drv_close = 1'b0;
							drv_open  = 1'b1;
							manual_on = 1'b1;
							run_on    = 1'b1;
							started   = START_MANUAL_OPEN;
						end else begin
							drv_open = 1'b0;
							if (run_on)
								stopped_now = 1'b1;
							manual_on = 1'b0;
							run_on    = 1'b0;
						end
						held_up = t.up_pressed;
					end
					if (chg_down) begin
						if (t.down_pressed) begin
							drv_open  = 1'b0;
							drv_close = 1'b1;
							manual_on = 1'b1;
							run_on    = 1'b1;
							started   = START_MANUAL_CLOSE;
						end else begin
							drv_close = 1'b0;
							if (run_on)
								stopped_now = 1'b1;
							manual_on = 1'b0;
							run_on    = 1'b0;
						end
						held_down = t.down_pressed;
					end
				end
			end
		end
		r.open_drive  = drv_open;
		r.close_drive = drv_close;
		r.running     = run_on;
		r.manual_mode = manual_on;
		r.start_event = started;
		r.stop_event  = stopped_now;
		return r;
	endfunction

	function automatic result_t res(logic o, logic c, logic r, logic m, start_t s,
			logic st, logic b);
		result_t x;
		x.open_drive    = o;
		x.close_drive   = c;
		x.running       = r;
		x.manual_mode   = m;
		x.start_event   = s;
		x.stop_event    = st;
		x.barrier_event = b;
		return x;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("mismatch: %s on result %0d: got %0d, expected %0d",
			field, results_seen, got, want);
		fail_count++;
	endtask

	task automatic add_step(action_t a, logic u, logic d, logic b, int n, logic typed,
			result_t w);
		step_t s;
		s.act   = a;
		s.up    = u;
		s.dn    = d;
		s.blk   = b;
		s.reps  = n;
		s.typed = typed;
		s.want  = w;
		steps.push_back(s);
	endtask

	task automatic send_tick(action_t a, logic u, logic d, logic b, logic typed,
			result_t w);
		int      gap;
		tick_t   t;
		result_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		t.action          = a;
		t.up_pressed      = u;
		t.down_pressed    = d;
		t.barrier_blocked = b;
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DATA_W'({b, d, u, a});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = shutter_tick(t);
		pending_drives.push_back(typed ? w : predicted);
		ticks_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_drives.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(logic [DUR_W-1:0] dur, logic en);
		cfg_we    <= 1'b1;
		cfg_index <= REG_RUN_DURATION;
		cfg_data  <= dur;
		@(posedge clk);
		duration_set = dur;
		cfg_index <= REG_BARRIER_ENABLE;
		cfg_data  <= DUR_W'(en);
		@(posedge clk);
		barrier_set = en;
		cfg_we <= 1'b0;
	endtask

	task automatic run_episode();
		int      len;
		int      kind;
		action_t a;
		logic    b;
		calm = ($urandom_range(0, 4) == 0);
		kind = $urandom_range(0, 9);
		if (kind < 3) begin
			len = $urandom_range(5, 25);
			repeat (len) begin
				sw_up   = 1'($urandom_range(0, 1));
				sw_down = 1'($urandom_range(0, 1));
				send_tick(action_t'($urandom_range(0, 3)), sw_up, sw_down,
					1'($urandom_range(0, 1)), 1'b0, '0);
			end
		end else begin
			if (kind < 7) begin
				case ($urandom_range(0, 4))
					0: begin
						sw_up   = 1'b0;
						sw_down = 1'b0;
					end
					1: begin
						sw_up   = 1'b1;
						sw_down = 1'b0;
					end
					2: begin
						sw_up   = 1'b0;
						sw_down = 1'b1;
					end
					3: begin
						sw_up   = 1'b1;
						sw_down = 1'b1;
					end
					default: ;
				endcase
				len = $urandom_range(50, 100);
			end else begin
				len = $urandom_range(20, 220);
			end
			for (int i = 0; i < len; i++) begin
				a = ACT_NONE;
				if (i == 0 && kind >= 7)
					a = action_t'($urandom_range(1, 2));
				else if ($urandom_range(0, 29) == 0)
					a = action_t'($urandom_range(1, 3));
				b = ($urandom_range(0, 39) == 0);
				send_tick(a, sw_up, sw_down, b, 1'b0, '0);
			end
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (m_tvalid && m_tready) begin
			if (pending_drives.size() == 0) begin
				report_mismatch("unexpected item", m_tdata, 0);
			end else begin
				want = pending_drives.pop_front();
				if (m_tdata[0] !== want.open_drive)
					report_mismatch("open_drive", m_tdata[0], want.open_drive);
				if (m_tdata[1] !== want.close_drive)
					report_mismatch("close_drive", m_tdata[1], want.close_drive);
				if (m_tdata[2] !== want.running)
					report_mismatch("running", m_tdata[2], want.running);
				if (m_tdata[3] !== want.manual_mode)
					report_mismatch("manual_mode", m_tdata[3], want.manual_mode);
				if (m_tdata[6:4] !== want.start_event)
					report_mismatch("start_event", m_tdata[6:4], want.start_event);
				if (m_tdata[7] !== want.stop_event)
					report_mismatch("stop_event", m_tdata[7], want.stop_event);
				if (m_tdata[8] !== want.barrier_event)
					report_mismatch("barrier_event", m_tdata[8], want.barrier_event);
			end
			results_seen++;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	initial begin
		logic [DUR_W-1:0] durations[6];
		logic             enables[6];
		int               target;
		durations = '{32'd0, 32'hFFFF_FFFF, 32'd7, 32'd40, 32'd1, 32'd150};
		enables   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

		// reset settings, switches locked out just after reset
		add_step(ACT_NONE,  0, 0, 0, 1,  1, res(0, 0, 0, 0, START_NONE, 0, 0));
		add_step(ACT_OPEN,  0, 0, 0, 1,  1, res(1, 0, 1, 0, START_TIMED_OPEN, 0, 0));
		add_step(ACT_CLOSE, 0, 0, 0, 1,  1, res(0, 1, 1, 0, START_TIMED_CLOSE, 1, 0));
		add_step(ACT_STOP,  0, 0, 0, 1,  1, res(0, 0, 0, 0, START_NONE, 1, 0));
		add_step(ACT_STOP,  0, 0, 0, 1,  1, res(0, 0, 0, 0, START_NONE, 0, 0));
		add_step(ACT_OPEN,  0, 0, 1, 1,  1, res(0, 0, 0, 0, START_TIMED_OPEN, 1, 1));
		add_step(ACT_NONE,  1, 1, 0, 1,  1, res(0, 0, 0, 0, START_NONE, 0, 0));
		add_step(ACT_CLOSE, 1, 0, 0, 1,  1, res(0, 1, 1, 0, START_TIMED_CLOSE, 0, 0));
		add_step(ACT_NONE,  0, 0, 1, 1,  1, res(0, 0, 0, 0, START_NONE, 1, 1));
		add_step(ACT_NONE,  0, 0, 0, 45, 1, res(0, 0, 0, 0, START_NONE, 0, 0));
		add_step(ACT_NONE,  1, 0, 0, 1,  1, res(1, 0, 1, 1, START_MANUAL_OPEN, 0, 0));
		// barrier on a manual run, release, manual close taken over by a timed run
		add_step(ACT_NONE,  1, 0, 1, 1,  0, '0);
		add_step(ACT_NONE,  1, 0, 0, 50, 0, '0);
		add_step(ACT_NONE,  0, 0, 0, 1,  0, '0);
		add_step(ACT_NONE,  0, 1, 0, 50, 0, '0);
		add_step(ACT_OPEN,  0, 1, 0, 1,  0, '0);
		add_step(ACT_NONE,  0, 1, 0, 49, 0, '0);
		// both held over a timed run, then both released
		add_step(ACT_NONE,  1, 1, 0, 50, 0, '0);
		add_step(ACT_NONE,  0, 0, 0, 50, 0, '0);
		// press one and release the other in the same tick
		add_step(ACT_NONE,  0, 1, 0, 51, 0, '0);
		add_step(ACT_NONE,  1, 0, 0, 1,  0, '0);
		add_step(ACT_STOP,  1, 0, 0, 1,  0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (steps[k])
			repeat (steps[k].reps)
				send_tick(steps[k].act, steps[k].up, steps[k].dn, steps[k].blk,
					steps[k].typed, steps[k].want);
		sw_up   = 1'b1;
		sw_down = 1'b0;
		drain();

		for (int p = 0; p < 6; p++) begin
			apply_settings(durations[p], enables[p]);
			target = ticks_sent + PHASE_TICKS;
			while (ticks_sent < target)
				run_episode();
			calm = 1'b0;
			drain();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
